// File: src/mlpq_pkg.sv
// Package: opcodes, status codes, field widths and cell row control for the priority queue.
package mlpq_pkg;

  localparam int OP_W     = 2;
  localparam int PRIO_W   = 5;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one command broadcast to every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
  } row_ctl_t;

endpackage

// File: src/mlpq_cell.sv
// One cell of the sorted queue row: holds one word and trades with its neighbors.
module mlpq_cell #(
  parameter int PW = 5,
  parameter int HW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mlpq_pkg::row_ctl_t ctl,
  input  logic [PW-1:0]     new_prio,
  input  logic [HW-1:0]     new_handle,
  input  logic              left_keep,
  input  logic              left_valid,
  input  logic [PW-1:0]     left_prio,
  input  logic [HW-1:0]     left_handle,
  input  logic              right_valid,
  input  logic [PW-1:0]     right_prio,
  input  logic [HW-1:0]     right_handle,
  output logic              valid,
  output logic [PW-1:0]     prio,
  output logic [HW-1:0]     handle,
  output logic              keep
);
  import mlpq_pkg::*;

  logic          valid_r, valid_nxt;
  logic [PW-1:0] prio_r, prio_nxt;
  logic [HW-1:0] handle_r, handle_nxt;

  // entries at or above the new priority stay put, preserving FIFO order per level
  assign keep = valid_r && (prio_r <= new_prio);

  always_comb begin
    valid_nxt  = valid_r;
    prio_nxt   = prio_r;
    handle_nxt = handle_r;
    if (ctl.push && !keep) begin
      if (left_keep) begin
        valid_nxt  = 1'b1;
        prio_nxt   = new_prio;
        handle_nxt = new_handle;
      end else begin
        valid_nxt  = left_valid;
        prio_nxt   = left_prio;
        handle_nxt = left_handle;
      end
    end else if (ctl.pop) begin
      valid_nxt  = right_valid;
      prio_nxt   = right_prio;
      handle_nxt = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r   <= prio_nxt;
    handle_r <= handle_nxt;
  end

  assign valid  = valid_r;
  assign prio   = prio_r;
  assign handle = handle_r;

endmodule

// File: src/multilevel_priority_fifo_top.sv
// Top level: 32-level priority ready queue built as a sorted row of cells.
// Command and result are registered: command register, then output register.
// A new command is refused while busy is high; busy is high in the cycle the
// registered command is applied to the whole cell row at once.
// Reset (synchronous, rst_n low) empties every cell; results cannot be stalled.
module multilevel_priority_fifo_top #(
  parameter int LEVELS      = 32,
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [mlpq_pkg::OP_W-1:0]        in_op,
  input  logic [mlpq_pkg::PRIO_W-1:0]      in_priority_req,
  input  logic [mlpq_pkg::HANDLE_W-1:0]    in_handle,
  output logic                             out_valid,
  output logic [mlpq_pkg::HANDLE_W-1:0]    out_handle_out,
  output logic [mlpq_pkg::PRIO_W-1:0]      out_priority_out,
  output logic [mlpq_pkg::STATUS_W-1:0]    out_status
);
  import mlpq_pkg::*;

  localparam int LVL_W = $clog2(LEVELS);

  logic                   cmd_valid_r;
  op_t                    cmd_op_r, cmd_op_nxt;
  logic [LVL_W-1:0]       cmd_prio_r, cmd_prio_nxt;
  logic [HANDLE_BITS-1:0] cmd_handle_r;

  logic                   out_valid_r;
  logic [HANDLE_W-1:0]    out_handle_r, out_handle_nxt;
  logic [PRIO_W-1:0]      out_prio_r, out_prio_nxt;
  status_t                out_status_r, out_status_nxt;

  row_ctl_t               ctl;
  logic                   full, empty, accept;

  logic                   c_valid  [CAPACITY];
  logic [LVL_W-1:0]       c_prio   [CAPACITY];
  logic [HANDLE_BITS-1:0] c_handle [CAPACITY];
  logic                   c_keep   [CAPACITY];

  assign accept = start && !busy;
  assign busy   = cmd_valid_r;

  always_comb begin
    cmd_op_nxt = op_t'(in_op);
    if (int'(in_priority_req) >= LEVELS) begin
      cmd_prio_nxt = LVL_W'(LEVELS - 1);
    end else begin
      cmd_prio_nxt = LVL_W'(in_priority_req);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= accept;
      out_valid_r <= cmd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op_r     <= cmd_op_nxt;
      cmd_prio_r   <= cmd_prio_nxt;
      cmd_handle_r <= HANDLE_BITS'(in_handle);
    end
    out_handle_r <= out_handle_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
  end

  assign full  = c_valid[CAPACITY-1];
  assign empty = !c_valid[0];

  always_comb begin
    ctl.push = cmd_valid_r && (cmd_op_r == OP_PUSH) && !full;
    ctl.pop  = cmd_valid_r && (cmd_op_r == OP_POP) && !empty;
  end

  always_comb begin
    out_handle_nxt = '0;
    out_prio_nxt   = '0;
    out_status_nxt = ST_OK;
    unique case (cmd_op_r)
      OP_PUSH: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end
      end
      OP_POP, OP_PEEK: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_handle_nxt = HANDLE_W'(c_handle[0]);
          out_prio_nxt   = PRIO_W'(c_prio[0]);
        end
      end
      default: begin
        out_status_nxt = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   l_keep, l_valid, r_valid;
    logic [LVL_W-1:0]       l_prio, r_prio;
    logic [HANDLE_BITS-1:0] l_handle, r_handle;

    if (i == 0) begin : g_first
      assign l_keep   = 1'b1;
      assign l_valid  = 1'b0;
      assign l_prio   = '0;
      assign l_handle = '0;
    end else begin : g_mid_l
      assign l_keep   = c_keep[i-1];
      assign l_valid  = c_valid[i-1];
      assign l_prio   = c_prio[i-1];
      assign l_handle = c_handle[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_valid  = 1'b0;
      assign r_prio   = '0;
      assign r_handle = '0;
    end else begin : g_mid_r
      assign r_valid  = c_valid[i+1];
      assign r_prio   = c_prio[i+1];
      assign r_handle = c_handle[i+1];
    end

    mlpq_cell #(
      .PW (LVL_W),
      .HW (HANDLE_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .new_prio     (cmd_prio_r),
      .new_handle   (cmd_handle_r),
      .left_keep    (l_keep),
      .left_valid   (l_valid),
      .left_prio    (l_prio),
      .left_handle  (l_handle),
      .right_valid  (r_valid),
      .right_prio   (r_prio),
      .right_handle (r_handle),
      .valid        (c_valid[i]),
      .prio         (c_prio[i]),
      .handle       (c_handle[i]),
      .keep         (c_keep[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_handle_out   = out_handle_r;
  assign out_priority_out = out_prio_r;
  assign out_status       = out_status_r;

endmodule
